// ===== hdl/aor_pkg.sv =====
// Shared types and constants of the auto-ranging ohm readout.
package aor_pkg;

    // Configuration register widths, reset values and indexes
    localparam int unsigned SCALE_W   = 20;
    localparam int unsigned THR_W     = 10;
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [SCALE_W-1:0]   SCALE_RST = 20'd220000;
    localparam logic [THR_W-1:0]     THR_RST   = 10'd32;
    localparam logic [CFG_IDX_W-1:0] CFG_UOHM_PER_COUNT      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_GAIN_THRESHOLD = 8'd1;

    // Reading and limit
    localparam int unsigned UOHM_W = 24;
    localparam logic [UOHM_W-1:0] LIMIT_UOHM = 24'd9999000;

    // Product compared against limit times gain, in a width that holds any product
    localparam int unsigned EXT_W = 37;
    localparam logic [EXT_W-1:0] LIMIT_P10  = 37'd99990000;
    localparam logic [EXT_W-1:0] LIMIT_P200 = 37'd1999800000;

    // Gain division: p/10 = (p>>1)/5, p/200 = (p>>3)/25, quotient by reciprocal
    localparam int unsigned QIN_W   = 28;
    localparam int unsigned QREC_W  = 29;
    localparam logic [QREC_W-1:0] RECIP_5  = 29'd429496730;  // shift 31
    localparam logic [QREC_W-1:0] RECIP_25 = 29'd343597384;  // shift 33

    // Decade thresholds and reciprocals
    localparam logic [UOHM_W-1:0] DECADE_3 = 24'd999999;
    localparam logic [UOHM_W-1:0] DECADE_2 = 24'd99999;
    localparam logic [UOHM_W-1:0] DECADE_1 = 24'd9999;
    localparam int unsigned DREC_W = 25;
    localparam logic [DREC_W-1:0] RECIP_1000 = 25'd17179870;  // shift 34
    localparam logic [DREC_W-1:0] RECIP_100  = 25'd21474837;  // shift 31
    localparam logic [DREC_W-1:0] RECIP_10   = 25'd26843546;  // shift 28
    localparam logic [DREC_W-1:0] RECIP_ONE  = 25'd1;         // shift 0

    // Four-digit split
    localparam int unsigned SHOWN_W = 14;
    localparam int unsigned PAIR_W  = 7;
    localparam logic [14:0] RECIP_D100 = 15'd20972;  // shift 21, exact below 2^14
    localparam logic [7:0]  RECIP_D10  = 8'd205;     // shift 11, exact below 2^7

    typedef struct packed {
        logic [1:0]        point_position;
        logic [UOHM_W-1:0] reading_uohm;
        logic              used_gain200;
        logic              clamped;
    } t_side;

endpackage

// ===== hdl/aor_digits.sv =====
// Two-stage pipelined split of a value below 10000 into four decimal digits.
module aor_digits
    import aor_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [SHOWN_W-1:0] i_shown,
    input  t_side              i_side,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [3:0]         o_thousands,
    output logic [3:0]         o_hundreds,
    output logic [3:0]         o_tens,
    output logic [3:0]         o_ones,
    output t_side              o_side
);

    // Split a value below 100 into tens and ones
    function automatic logic [7:0] split10(input logic [PAIR_W-1:0] x);
        logic [14:0]       prod;
        logic [3:0]        t;
        logic [PAIR_W-1:0] rem;
        prod = 15'(x) * 15'(RECIP_D10);
        t    = prod[14:11];
        rem  = x - PAIR_W'(t) * PAIR_W'(10);
        return {t, rem[3:0]};
    endfunction

    logic              r_v7;
    logic              r_v8;
    logic              w_rdy7;
    logic              w_rdy8;
    logic [PAIR_W-1:0] r_hi;
    logic [PAIR_W-1:0] r_lo;
    t_side             r_s7_side;
    logic [28:0]       w_prod;
    logic [PAIR_W-1:0] n_hi;
    logic [SHOWN_W-1:0] w_lo_full;
    logic [7:0]        w_hi_split;
    logic [7:0]        w_lo_split;
    logic [3:0]        r_thousands;
    logic [3:0]        r_hundreds;
    logic [3:0]        r_tens;
    logic [3:0]        r_ones;
    t_side             r_s8_side;

    assign w_rdy8  = !r_v8 || i_ready;
    assign w_rdy7  = !r_v7 || w_rdy8;
    assign o_ready = w_rdy7;

    always_comb begin
        w_prod    = 29'(i_shown) * 29'(RECIP_D100);
        n_hi      = w_prod[27:21];
        w_lo_full = i_shown - SHOWN_W'(n_hi) * SHOWN_W'(100);
    end

    assign w_hi_split = split10(r_hi);
    assign w_lo_split = split10(r_lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else begin
            if (w_rdy7) begin
                r_v7 <= i_valid;
            end
            if (w_rdy8) begin
                r_v8 <= r_v7;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy7) begin
            r_hi      <= n_hi;
            r_lo      <= w_lo_full[PAIR_W-1:0];
            r_s7_side <= i_side;
        end
        if (w_rdy8) begin
            r_thousands <= w_hi_split[7:4];
            r_hundreds  <= w_hi_split[3:0];
            r_tens      <= w_lo_split[7:4];
            r_ones      <= w_lo_split[3:0];
            r_s8_side   <= r_s7_side;
        end
    end

    assign o_valid     = r_v8;
    assign o_thousands = r_thousands;
    assign o_hundreds  = r_hundreds;
    assign o_tens      = r_tens;
    assign o_ones      = r_ones;
    assign o_side      = r_s8_side;

endmodule

// ===== hdl/autorange_ohm_readout.sv =====
// Top level of the auto-ranging ohm readout pipeline.
//
// Each input transaction carries one pair of ADC counts taken at 10x and 200x
// gain; each output transaction carries the reading as four decimal digits
// with a point position, the clamped value in micro-ohms, and flags for the
// gain used and for the clamp at 9999000 micro-ohms. The block accepts one
// transaction every clock cycle while the output is not stalled. Its stages
// are: count selection, scale multiply, clamp check, gain division by
// reciprocal multiply, decade choice, decade division, and two digit-split
// stages. A stalled output backs up stage by stage, so empty stages still
// fill while the result waits. Configuration writes take effect at once and
// must only be made while the pipeline is empty; o_cfg_ready is always high.
module autorange_ohm_readout
    import aor_pkg::*;
#(
    parameter int unsigned ADC_BITS = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Input transactions
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // [ADC_BITS-1:0] count_gain10, [2*ADC_BITS-1:ADC_BITS] count_gain200, zero pad
    input  logic [((2*ADC_BITS+7)/8)*8-1:0] s_axis_tdata,
    // Output transactions
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [3:0] digit_thousands, [7:4] digit_hundreds, [11:8] digit_tens,
    // [15:12] digit_ones, [17:16] point_position, [41:18] reading_uohm, zero pad
    output logic [47:0]               m_axis_tdata,
    // [0] used_gain200, [1] clamped
    output logic [1:0]                m_axis_tuser,
    // Configuration writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [SCALE_W-1:0]        i_cfg_data
);

    localparam int unsigned PW    = ADC_BITS + SCALE_W;
    localparam int unsigned CMP_W = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;
    localparam int unsigned NSTG  = 6;

    // Configuration registers
    logic [SCALE_W-1:0] r_uohm_per_count;
    logic [THR_W-1:0]   r_high_gain_threshold;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uohm_per_count      <= SCALE_RST;
            r_high_gain_threshold <= THR_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_UOHM_PER_COUNT) begin
                r_uohm_per_count <= i_cfg_data;
            end else if (i_cfg_index == CFG_HIGH_GAIN_THRESHOLD) begin
                r_high_gain_threshold <= i_cfg_data[THR_W-1:0];
            end
        end
    end

    // Stage valid bits and backpressure: a stage loads when empty or draining
    logic [NSTG:1] r_vld;
    logic [NSTG:1] n_vld;
    logic [NSTG+1:1] w_rdy;
    logic          w_dig_ready;

    always_comb begin
        w_rdy[NSTG+1] = w_dig_ready;
        for (int i = NSTG; i >= 1; i--) begin
            w_rdy[i] = !r_vld[i] || w_rdy[i+1];
        end
        n_vld = {r_vld[NSTG-1:1], s_axis_tvalid};
    end

    assign s_axis_tready = w_rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int i = 1; i <= NSTG; i++) begin
                if (w_rdy[i]) begin
                    r_vld[i] <= n_vld[i];
                end
            end
        end
    end

    // Stage 1: mask counts, pick the gain
    logic [ADC_BITS-1:0] w_c10;
    logic [ADC_BITS-1:0] w_c200;
    logic                n_s1_g200;
    logic [ADC_BITS-1:0] r_s1_cnt;
    logic                r_s1_g200;

    assign w_c10     = s_axis_tdata[ADC_BITS-1:0];
    assign w_c200    = s_axis_tdata[2*ADC_BITS-1:ADC_BITS];
    assign n_s1_g200 = !(CMP_W'(w_c10) > CMP_W'(r_high_gain_threshold));

    // Stage 2: count times scale
    logic [PW-1:0] r_s2_prod;
    logic          r_s2_g200;

    // Stage 3: clamp decision, prepare the quotient input
    logic [EXT_W-1:0] w_ext;
    logic             n_s3_clip;
    logic [QIN_W-1:0] n_s3_x;
    logic [QIN_W-1:0] r_s3_x;
    logic             r_s3_g200;
    logic             r_s3_clip;

    always_comb begin
        w_ext     = {{(EXT_W-PW){1'b0}}, r_s2_prod};
        n_s3_clip = r_s2_g200 ? (w_ext >= LIMIT_P200) : (w_ext >= LIMIT_P10);
        n_s3_x    = r_s2_g200 ? w_ext[30:3] : w_ext[28:1];
    end

    // Stage 4: divide by the gain through a reciprocal, apply the clamp
    logic [QIN_W+QREC_W-1:0] w_qprod;
    logic [UOHM_W-1:0]       w_q;
    logic [UOHM_W-1:0]       r_s4_v;
    logic                    r_s4_g200;
    logic                    r_s4_clip;

    always_comb begin
        w_qprod = (QIN_W+QREC_W)'(r_s3_x) *
                  (QIN_W+QREC_W)'(r_s3_g200 ? RECIP_25 : RECIP_5);
        w_q     = r_s3_g200 ? w_qprod[56:33] : w_qprod[54:31];
    end

    // Stage 5: choose the decade
    logic [1:0] n_point;
    t_side      r_s5_side;

    always_comb begin
        if (r_s4_v > DECADE_3) begin
            n_point = 2'd3;
        end else if (r_s4_v > DECADE_2) begin
            n_point = 2'd2;
        end else if (r_s4_v > DECADE_1) begin
            n_point = 2'd1;
        end else begin
            n_point = 2'd0;
        end
    end

    // Stage 6: divide by the decade through a reciprocal
    logic [UOHM_W+DREC_W-1:0] w_dprod;
    logic [SHOWN_W-1:0]       n_shown;
    logic [SHOWN_W-1:0]       r_s6_shown;
    t_side                    r_s6_side;

    always_comb begin
        case (r_s5_side.point_position)
            2'd3: begin
                w_dprod = (UOHM_W+DREC_W)'(r_s5_side.reading_uohm) *
                          (UOHM_W+DREC_W)'(RECIP_1000);
                n_shown = w_dprod[34+SHOWN_W-1:34];
            end
            2'd2: begin
                w_dprod = (UOHM_W+DREC_W)'(r_s5_side.reading_uohm) *
                          (UOHM_W+DREC_W)'(RECIP_100);
                n_shown = w_dprod[31+SHOWN_W-1:31];
            end
            2'd1: begin
                w_dprod = (UOHM_W+DREC_W)'(r_s5_side.reading_uohm) *
                          (UOHM_W+DREC_W)'(RECIP_10);
                n_shown = w_dprod[28+SHOWN_W-1:28];
            end
            default: begin
                w_dprod = (UOHM_W+DREC_W)'(r_s5_side.reading_uohm) *
                          (UOHM_W+DREC_W)'(RECIP_ONE);
                n_shown = w_dprod[SHOWN_W-1:0];
            end
        endcase
    end

    // Payload registers, advanced with their stage
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_s1_cnt  <= n_s1_g200 ? w_c200 : w_c10;
            r_s1_g200 <= n_s1_g200;
        end
        if (w_rdy[2]) begin
            r_s2_prod <= PW'(r_s1_cnt) * PW'(r_uohm_per_count);
            r_s2_g200 <= r_s1_g200;
        end
        if (w_rdy[3]) begin
            r_s3_x    <= n_s3_x;
            r_s3_g200 <= r_s2_g200;
            r_s3_clip <= n_s3_clip;
        end
        if (w_rdy[4]) begin
            r_s4_v    <= r_s3_clip ? LIMIT_UOHM : w_q;
            r_s4_g200 <= r_s3_g200;
            r_s4_clip <= r_s3_clip;
        end
        if (w_rdy[5]) begin
            r_s5_side.point_position <= n_point;
            r_s5_side.reading_uohm   <= r_s4_v;
            r_s5_side.used_gain200   <= r_s4_g200;
            r_s5_side.clamped        <= r_s4_clip;
        end
        if (w_rdy[6]) begin
            r_s6_shown <= n_shown;
            r_s6_side  <= r_s5_side;
        end
    end

    // Stages 7 and 8: digit split and output register
    logic [3:0] w_thousands;
    logic [3:0] w_hundreds;
    logic [3:0] w_tens;
    logic [3:0] w_ones;
    t_side      w_out_side;

    aor_digits u_digits (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_vld[NSTG]),
        .o_ready     (w_dig_ready),
        .i_shown     (r_s6_shown),
        .i_side      (r_s6_side),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_thousands (w_thousands),
        .o_hundreds  (w_hundreds),
        .o_tens      (w_tens),
        .o_ones      (w_ones),
        .o_side      (w_out_side)
    );

    assign m_axis_tdata = {6'd0, w_out_side.reading_uohm, w_out_side.point_position,
                           w_ones, w_tens, w_hundreds, w_thousands};
    assign m_axis_tuser = {w_out_side.clamped, w_out_side.used_gain200};

endmodule

// ===== hdl/aor_checker.sv =====
// Port-level checks of the ohm readout, bound to the top level.
module aor_checker
    import aor_pkg::*;
#(
    parameter int unsigned ADC_BITS = 10
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [((2*ADC_BITS+7)/8)*8-1:0] s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [47:0]                     m_axis_tdata,
    input logic [1:0]                      m_axis_tuser,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [CFG_IDX_W-1:0]            i_cfg_index,
    input logic [SCALE_W-1:0]              i_cfg_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("output transaction changed while stalled");

    // Drop all results on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid straight after reset");

    // Every digit is decimal and the reading stays at or under the limit
    a_digits_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd9 && m_axis_tdata[7:4] <= 4'd9
        && m_axis_tdata[11:8] <= 4'd9 && m_axis_tdata[15:12] <= 4'd9
        && m_axis_tdata[41:18] <= LIMIT_UOHM)
        else $error("digit or reading out of range");

    // The clamp flag marks exactly the limit value
    a_clamp_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser[1] == (m_axis_tdata[41:18] == LIMIT_UOHM))
        else $error("clamp flag disagrees with reading");

    // The point position follows the decade of the reading
    a_point_decade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
        (m_axis_tdata[17:16] == 2'd3) == (m_axis_tdata[41:18] > DECADE_3)
        && (m_axis_tdata[17:16] == 2'd0) == (m_axis_tdata[41:18] <= DECADE_1))
        else $error("point position disagrees with reading");

endmodule

bind autorange_ohm_readout aor_checker #(.ADC_BITS(ADC_BITS)) u_aor_checker (.*);

// ===== test/aor_readout_checker.sv =====
// Checker of the auto-ranging ohm readout: predicts every reading and compares it with the output.
module aor_readout_checker
    import aor_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_tvalid,
    input  logic                 i_in_tready,
    input  logic [23:0]          i_in_tdata,
    input  logic                 i_out_tvalid,
    input  logic                 i_out_tready,
    input  logic [47:0]          i_out_tdata,
    input  logic [1:0]           i_out_tuser,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SCALE_W-1:0]   i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]        thousands;
        logic [3:0]        hundreds;
        logic [3:0]        tens;
        logic [3:0]        ones;
        logic [1:0]        point;
        logic [UOHM_W-1:0] uohm;
        logic              gain200;
        logic              clamped;
    } readout_t;

    logic [SCALE_W-1:0] uohm_scale;
    logic [THR_W-1:0]   gain_thr;
    readout_t           awaited_readouts[$];
    int                 mismatches = 0;
    int                 awaited_n  = 0;

    assign o_errors  = mismatches;
    assign o_pending = awaited_n;

    // Work out the displayed reading of one pair of counts
    function automatic readout_t predict_readout(input logic [9:0] c10, input logic [9:0] c200,
                                                 input logic [SCALE_W-1:0] scale,
                                                 input logic [THR_W-1:0] thr);
        longint unsigned raw;
        longint unsigned v;
        longint unsigned shown;
        readout_t        r;
        if (c10 > thr) begin
            raw       = (longint'(c10) * longint'(scale)) / 10;
            r.gain200 = 1'b0;
        end else begin
            raw       = (longint'(c200) * longint'(scale)) / 200;
            r.gain200 = 1'b1;
        end
        // Saturate at the display limit; hitting it exactly still counts as clamped
        r.clamped = (raw >= longint'(LIMIT_UOHM));
        v = r.clamped ? longint'(LIMIT_UOHM) : raw;
        if (v > longint'(DECADE_3)) begin
            shown   = v / 1000;
            r.point = 2'd3;
        end else if (v > longint'(DECADE_2)) begin
            shown   = v / 100;
            r.point = 2'd2;
        end else if (v > longint'(DECADE_1)) begin
            shown   = v / 10;
            r.point = 2'd1;
        end else begin
            shown   = v;
            r.point = 2'd0;
        end
        r.ones      = 4'(shown % 10);
        r.tens      = 4'((shown / 10) % 10);
        r.hundreds  = 4'((shown / 100) % 10);
        r.thousands = 4'((shown / 1000) % 10);
        r.uohm      = v[UOHM_W-1:0];
        return r;
    endfunction

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        readout_t want;
        readout_t got;
        if (!i_rst_n) begin
            uohm_scale <= SCALE_RST;
            gain_thr   <= THR_RST;
            awaited_readouts.delete();
            awaited_n = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_UOHM_PER_COUNT:      uohm_scale <= i_cfg_data;
                    CFG_HIGH_GAIN_THRESHOLD: gain_thr   <= i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_tvalid && i_in_tready)
                awaited_readouts.push_back(predict_readout(i_in_tdata[9:0], i_in_tdata[19:10],
                                                           uohm_scale, gain_thr));
            if (i_out_tvalid && i_out_tready) begin
                got.thousands = i_out_tdata[3:0];
                got.hundreds  = i_out_tdata[7:4];
                got.tens      = i_out_tdata[11:8];
                got.ones      = i_out_tdata[15:12];
                got.point     = i_out_tdata[17:16];
                got.uohm      = i_out_tdata[41:18];
                got.gain200   = i_out_tuser[0];
                got.clamped   = i_out_tuser[1];
                if (awaited_readouts.size() == 0) begin
                    $display("%0t: unexpected reading, expected none, actual %0d uohm",
                             $time, got.uohm);
                    mismatches++;
                end else begin
                    want = awaited_readouts.pop_front();
                    compare_field("digit_thousands", want.thousands, got.thousands);
                    compare_field("digit_hundreds", want.hundreds, got.hundreds);
                    compare_field("digit_tens", want.tens, got.tens);
                    compare_field("digit_ones", want.ones, got.ones);
                    compare_field("point_position", want.point, got.point);
                    compare_field("reading_uohm", want.uohm, got.uohm);
                    compare_field("used_gain200", want.gain200, got.gain200);
                    compare_field("clamped", want.clamped, got.clamped);
                end
            end
            awaited_n = awaited_readouts.size();
        end
    end

endmodule

// ===== test/tb_autorange_ohm_readout.sv =====
// Testbench top of the auto-ranging ohm readout: stimulus, back-pressure and verdict.
module tb_autorange_ohm_readout;
    import aor_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADC_BITS        = 10;
    localparam int IN_W            = ((2 * ADC_BITS + 7) / 8) * 8;
    localparam int TOTAL_READINGS  = 1950;
    localparam int HOLD_OFF_CYCLES = 100;   // long receiver stall that backs up the pipeline
    localparam int SETTLE_CYCLES   = 12;    // margin for the pipeline to drain
    localparam int STALL_LIMIT     = 4000;  // cycles without any transaction before giving up

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 s_axis_tvalid  = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata   = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready  = 1'b0;
    logic [47:0]          m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 i_cfg_valid    = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [SCALE_W-1:0]   i_cfg_data     = '0;

    int errors;
    int pending;
    int readings_sent = 0;
    int quiet_cycles  = 0;
    bit sender_gaps   = 1'b1;   // sender idles between transactions when set

    autorange_ohm_readout #(
        .ADC_BITS(ADC_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    aor_readout_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_tvalid (s_axis_tvalid),
        .i_in_tready (s_axis_tready),
        .i_in_tdata  (s_axis_tdata),
        .i_out_tvalid(m_axis_tvalid),
        .i_out_tready(m_axis_tready),
        .i_out_tdata (m_axis_tdata),
        .i_out_tuser (m_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: count cycles in which no transaction moves on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Receiver: random stalls before each reading, every third stretch of 150 readings taken
    // without stalls, and two long hold-offs so that the pipeline fills and stalls its input
    initial begin : receiver
        int gap;
        int taken;
        taken = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken == 400 || taken == 1200) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if ((taken / 150) % 3 != 2) begin
                gap = $urandom_range(0, 4);
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            taken++;
        end
    end

    // Offer one pair of counts and hold it until the transaction completes
    task automatic send_reading(input logic [9:0] c10, input logic [9:0] c200);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W - 2 * ADC_BITS){1'b0}}, c200, c10};
        do @(posedge i_clk); while (!s_axis_tready);
        readings_sent++;
    endtask

    // Drop the input, let the checker log the last transaction, wait until
    // every reading has come back, then let the pipeline drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers back to back; the upper threshold bits carry junk to be ignored
    task automatic load_config(input logic [SCALE_W-1:0] scale, input logic [THR_W-1:0] thr);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_UOHM_PER_COUNT;
        i_cfg_data  <= scale;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_HIGH_GAIN_THRESHOLD;
        i_cfg_data  <= {SCALE_W'($urandom_range(0, 1023)) << THR_W} | SCALE_W'(thr);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [SCALE_W-1:0] scale;
        logic [THR_W-1:0]   thr;
        logic [9:0]         c10;
        logic [9:0]         c200;
        int                 n;
        int                 width;
        int                 near;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset settings: count extremes and both sides of the default threshold
        send_reading(10'd0, 10'd0);
        send_reading(10'd1023, 10'd1023);
        send_reading(10'd32, 10'd1023);
        send_reading(10'd33, 10'd0);
        send_reading(10'd1023, 10'd0);

        // Decade edges: 999999 against 1000000, 99999 against 100000, 9999 against 10000
        settle();
        load_config(20'd999999, 10'd9);
        send_reading(10'd10, 10'd0);
        send_reading(10'd9, 10'd2);
        send_reading(10'd9, 10'd3);
        settle();
        load_config(20'd1000000, 10'd9);
        send_reading(10'd10, 10'd0);
        send_reading(10'd9, 10'd2);
        settle();
        load_config(20'd99999, 10'd0);
        send_reading(10'd10, 10'd0);
        send_reading(10'd0, 10'd1);
        settle();
        load_config(20'd100000, 10'd0);
        send_reading(10'd10, 10'd0);

        // Reading landing exactly on the limit, and just under it
        settle();
        load_config(20'd99990, 10'd0);
        send_reading(10'd1000, 10'd0);
        send_reading(10'd999, 10'd0);

        // Zero scale with the highest threshold: always the 200x count, always zero
        settle();
        load_config(20'd0, 10'd1023);
        send_reading(10'd1023, 10'd1023);
        send_reading(10'd0, 10'd1023);

        // Largest scale with a zero threshold
        settle();
        load_config(20'd1048575, 10'd0);
        send_reading(10'd0, 10'd1023);
        send_reading(10'd1023, 10'd1023);
        send_reading(10'd1, 10'd0);

        settle();
        load_config(20'd1, 10'd1023);
        send_reading(10'd1023, 10'd1023);

        // Random phases: fresh settings each time, scale spread over every magnitude
        while (readings_sent < TOTAL_READINGS) begin
            settle();
            case ($urandom_range(0, 7))
                0: scale = '0;
                1: scale = '1;
                2: scale = 20'd1;
                3: scale = SCALE_RST;
                default: begin
                    width = $urandom_range(1, SCALE_W);
                    scale = SCALE_W'($urandom & ((1 << width) - 1));
                end
            endcase
            case ($urandom_range(0, 5))
                0: thr = '0;
                1: thr = '1;
                2: thr = THR_W'($urandom_range(0, 64));
                default: thr = THR_W'($urandom_range(0, 1023));
            endcase
            load_config(scale, thr);
            sender_gaps = ($urandom_range(0, 3) != 0);
            n = $urandom_range(60, 200);
            repeat (n) begin
                case ($urandom_range(0, 7))
                    0, 1: begin
                        // Hug the gain switch-over point
                        near = int'(thr) + $urandom_range(0, 4) - 2;
                        c10  = (near < 0) ? 10'd0 : (near > 1023) ? 10'd1023 : 10'(near);
                    end
                    2: c10 = 10'($urandom_range(0, 63));
                    3: c10 = $urandom_range(0, 1) ? 10'd0 : 10'd1023;
                    default: c10 = 10'($urandom);
                endcase
                case ($urandom_range(0, 7))
                    0: c200 = 10'd0;
                    1: c200 = 10'd1023;
                    default: c200 = 10'($urandom);
                endcase
                send_reading(c10, c200);
            end
        end

        settle();
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/aor_pkg.sv
hdl/aor_digits.sv
hdl/autorange_ohm_readout.sv
hdl/aor_checker.sv
test/aor_readout_checker.sv
test/tb_autorange_ohm_readout.sv
